[sv/smw_pkg.sv]
// smw_pkg: operation codes and shared types for the sign-magnitude word alu
// no dependencies
package smw_pkg;

   typedef enum logic [4:0] {
      OP_MBR_TO_AC = 5'd0,
      OP_ABS       = 5'd1,
      OP_NEG       = 5'd2,
      OP_NEGABS    = 5'd3,
      OP_AC_TO_MBR = 5'd4,
      OP_ADR_LEFT  = 5'd5,
      OP_ADR_RIGHT = 5'd6,
      OP_ADD       = 5'd7,
      OP_ADD_ABS   = 5'd8,
      OP_SUB       = 5'd9,
      OP_SUB_ABS   = 5'd10,
      OP_MQ_TO_AC  = 5'd11,
      OP_MBR_TO_MQ = 5'd12,
      OP_MUL       = 5'd13,
      OP_DIV       = 5'd14,
      OP_LSH       = 5'd15,
      OP_RSH       = 5'd16,
      OP_SIGN      = 5'd17
   } op_type;

   localparam int unsigned ADR_LEFT_SHIFT = 20;

   // control that travels along the cell chain with each beat
   typedef struct packed {
      logic   valid;
      logic   is_mul;
      logic   is_div;
      logic   neg_a;
      logic   neg_b;
   } ctl_type;

endpackage

[sv/smw_cell.sv]
// smw_cell: one stage of the arithmetic chain, does one multiply-add bit
// or one restoring-divide bit per beat, then hands everything to the next cell
// depends on smw_pkg
module smw_cell
   import smw_pkg::*;
#(
   parameter int MAG_BITS = 39,
   parameter int STEP     = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ctl_type               ctl_i,
   input  logic [MAG_BITS-1:0]   a_i,
   input  logic [MAG_BITS-1:0]   b_i,
   input  logic [2*MAG_BITS-1:0] acc_i,
   output ctl_type               ctl_o,
   output logic [MAG_BITS-1:0]   a_o,
   output logic [MAG_BITS-1:0]   b_o,
   output logic [2*MAG_BITS-1:0] acc_o
);

   localparam int ACC_BITS = 2 * MAG_BITS;

   ctl_type                ctl_ff;
   logic [MAG_BITS-1:0]    a_ff, a_in;
   logic [MAG_BITS-1:0]    b_ff;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [MAG_BITS:0]      part_rem;
   logic [MAG_BITS:0]      diff;

   // multiply: a = multiplicand, b = multiplier, acc = product so far
   // divide: a = quotient bits/dividend shifting, b = divisor, acc[MAG_BITS-1:0] = remainder
   always_comb begin
      a_in     = a_i;
      acc_in   = acc_i;
      part_rem = '0;
      diff     = '0;
      if (ctl_i.is_mul) begin
         if (b_i[STEP]) begin
            acc_in = acc_i + (ACC_BITS'(a_i) << STEP);
         end
      end else if (ctl_i.is_div) begin
         part_rem = {acc_i[MAG_BITS-1:0], a_i[MAG_BITS-1]};
         diff     = part_rem - {1'b0, b_i};
         if (!diff[MAG_BITS]) begin
            acc_in = {{MAG_BITS{1'b0}}, diff[MAG_BITS-1:0]};
            a_in   = {a_i[MAG_BITS-2:0], 1'b1};
         end else begin
            acc_in = {{MAG_BITS{1'b0}}, part_rem[MAG_BITS-1:0]};
            a_in   = {a_i[MAG_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
      if (advance) begin
         a_ff   <= a_in;
         b_ff   <= b_i;
         acc_ff <= acc_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign a_o   = a_ff;
   assign b_o   = b_ff;
   assign acc_o = acc_ff;

endmodule

[sv/smw_front.sv]
// smw_front: decodes a request beat, computes the operations that need no cell arithmetic and
// prepares the operands that enter the cell chain
// depends on smw_pkg
module smw_front
   import smw_pkg::*;
#(
   parameter int WORD_BITS    = 40,
   parameter int ADDRESS_BITS = 12
) (
   input  logic [4:0]           func,
   input  logic [WORD_BITS-1:0] ac,
   input  logic [WORD_BITS-1:0] mbr,
   input  logic [WORD_BITS-1:0] mq,
   output logic [WORD_BITS-1:0] ac_o,
   output logic                 ac_w,
   output logic [WORD_BITS-1:0] mq_o,
   output logic                 mq_w,
   output logic [WORD_BITS-1:0] mbr_o,
   output logic                 mbr_w,
   output logic                 ovf,
   output logic                 dz,
   output logic                 is_mul,
   output logic                 is_div,
   output logic                 sign_a,
   output logic                 sign_b,
   output logic [WORD_BITS-2:0] mag_a,
   output logic [WORD_BITS-2:0] mag_b
);

   localparam int MB = WORD_BITS - 1;

   logic          acs, mbs, mqs;
   logic [MB-1:0] acm, mbm, mqm;
   logic          bs;
   logic [MB:0]   sum;
   logic [MB-1:0] mag;
   logic          rs;
   logic [WORD_BITS+ADR_LEFT_SHIFT-1:0] adr_wide;

   assign acs = ac[MB];
   assign mbs = mbr[MB];
   assign mqs = mq[MB];
   assign acm = ac[MB-1:0];
   assign mbm = mbr[MB-1:0];
   assign mqm = mq[MB-1:0];
   assign adr_wide = (WORD_BITS+ADR_LEFT_SHIFT)'(ac[ADDRESS_BITS-1:0]) << ADR_LEFT_SHIFT;

   always_comb begin
      bs = mbs;
      case (op_type'(func))
         OP_ADD_ABS: bs = 1'b0;
         OP_SUB:     bs = ~mbs;
         OP_SUB_ABS: bs = 1'b1;
         default:    bs = mbs;
      endcase
      sum = '0;
      mag = '0;
      rs  = acs;
      if (acs == bs) begin
         sum = {1'b0, acm} + {1'b0, mbm};
         mag = sum[MB-1:0];
         rs  = acs;
      end else if (acm >= mbm) begin
         mag = acm - mbm;
         rs  = acs;
      end else begin
         mag = mbm - acm;
         rs  = bs;
      end
   end

   always_comb begin
      ac_o = '0; ac_w = 1'b0; mq_o = '0; mq_w = 1'b0;
      mbr_o = '0; mbr_w = 1'b0; ovf = 1'b0; dz = 1'b0;
      is_mul = 1'b0; is_div = 1'b0;
      sign_a = acs; sign_b = mbs; mag_a = acm; mag_b = mbm;
      case (func)
         OP_MBR_TO_AC: begin ac_o = mbr; ac_w = 1'b1; end
         OP_ABS:       begin ac_o = {1'b0, mbm}; ac_w = 1'b1; end
         OP_NEG:       begin ac_o = {~mbs, mbm}; ac_w = 1'b1; end
         OP_NEGABS:    begin ac_o = {1'b1, mbm}; ac_w = 1'b1; end
         OP_AC_TO_MBR: begin mbr_o = ac; mbr_w = 1'b1; end
         OP_ADR_LEFT:  begin mbr_o = adr_wide[WORD_BITS-1:0]; mbr_w = 1'b1; end
         OP_ADR_RIGHT: begin
            mbr_o = WORD_BITS'(ac[ADDRESS_BITS-1:0]); mbr_w = 1'b1;
         end
         OP_ADD, OP_ADD_ABS, OP_SUB, OP_SUB_ABS: begin
            ac_o = (mag == '0) ? '0 : {rs, mag};
            ac_w = 1'b1;
            ovf  = sum[MB];
         end
         OP_MQ_TO_AC:  begin ac_o = mq; ac_w = 1'b1; end
         OP_MBR_TO_MQ: begin mq_o = mbr; mq_w = 1'b1; end
         OP_MUL: begin
            is_mul = 1'b1; sign_a = mbs; sign_b = mqs; mag_a = mbm; mag_b = mqm;
         end
         OP_DIV: begin
            if (mbm == '0) begin
               dz = 1'b1;
            end else begin
               is_div = 1'b1;
            end
         end
         OP_LSH: begin ac_o = {acs, acm[MB-2:0], 1'b0}; ac_w = 1'b1; end
         OP_RSH: begin ac_o = {acs, 1'b0, acm[MB-1:1]}; ac_w = 1'b1; end
         OP_SIGN: begin mbr_o = WORD_BITS'(acs); mbr_w = 1'b1; end
         default: ;
      endcase
   end

endmodule

[sv/sign_magnitude_word_alu_unit.sv]
// sign_magnitude_word_alu_unit: top level of the sign-magnitude word alu
// depends on smw_pkg, smw_front, smw_cell
//
// usage: a request beat (req_valid high, req_stall low) carries an operation
// code and the current ac, mbr and mq words. one response beat per request
// gives new ac, mq and mbr values with write enables plus overflow and
// divide_by_zero flags, in request order.
// every operation travels through the same chain of WORD_BITS-1 cells, one
// cell per magnitude bit; multiply adds one partial product per cell and
// divide develops one quotient bit per cell. a result passes the cells and
// then the output register (39 cells at the default width).
// throughput is one beat per cycle while not stalled; the chain moves as a whole.
// when rsp_stall is high and the output register holds a beat, the whole
// chain holds and req_stall follows; otherwise beats flow every cycle.
// reset (synchronous, active high) clears every valid in the chain and the
// output register; payload registers are not reset.
module sign_magnitude_word_alu_unit
   import smw_pkg::*;
#(
   parameter int WORD_BITS    = 40,
   parameter int ADDRESS_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [4:0]           req_func,
   input  logic [WORD_BITS-1:0] req_ac_in,
   input  logic [WORD_BITS-1:0] req_mbr_in,
   input  logic [WORD_BITS-1:0] req_mq_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_ac_out,
   output logic                 rsp_ac_write,
   output logic [WORD_BITS-1:0] rsp_mq_out,
   output logic                 rsp_mq_write,
   output logic [WORD_BITS-1:0] rsp_mbr_out,
   output logic                 rsp_mbr_write,
   output logic                 rsp_overflow,
   output logic                 rsp_divide_by_zero
);

   localparam int MB = WORD_BITS - 1;
   localparam int SIDE = 3 * WORD_BITS + 5;

   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic [WORD_BITS-1:0] f_ac, f_mq, f_mbr;
   logic f_acw, f_mqw, f_mbrw, f_ovf, f_dz, f_mul, f_div, f_sa, f_sb;
   logic [MB-1:0] f_ma, f_mb;

   smw_front #(.WORD_BITS(WORD_BITS), .ADDRESS_BITS(ADDRESS_BITS)) u_front (
      .func(req_func), .ac(req_ac_in), .mbr(req_mbr_in), .mq(req_mq_in),
      .ac_o(f_ac), .ac_w(f_acw), .mq_o(f_mq), .mq_w(f_mqw),
      .mbr_o(f_mbr), .mbr_w(f_mbrw), .ovf(f_ovf), .dz(f_dz),
      .is_mul(f_mul), .is_div(f_div), .sign_a(f_sa), .sign_b(f_sb),
      .mag_a(f_ma), .mag_b(f_mb)
   );

   ctl_type           ctl  [MB+1];
   logic [MB-1:0]     av   [MB+1];
   logic [MB-1:0]     bv   [MB+1];
   logic [2*MB-1:0]   accv [MB+1];
   logic [SIDE-1:0]   side_ff [MB];

   assign ctl[0]  = '{valid: req_valid, is_mul: f_mul, is_div: f_div,
                      neg_a: f_sa, neg_b: f_sb};
   assign av[0]   = f_ma;
   assign bv[0]   = f_mb;
   assign accv[0] = '0;

   // cells run in reverse bit order for divide; multiply uses the cell's own bit
   for (genvar i = 0; i < MB; i++) begin : g_chain
      smw_cell #(.MAG_BITS(MB), .STEP(i)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .ctl_i(ctl[i]), .a_i(av[i]), .b_i(bv[i]), .acc_i(accv[i]),
         .ctl_o(ctl[i+1]), .a_o(av[i+1]), .b_o(bv[i+1]), .acc_o(accv[i+1])
      );
      if (i == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (advance) begin
               side_ff[i] <= {f_ac, f_acw, f_mq, f_mqw, f_mbr, f_mbrw, f_ovf, f_dz};
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (advance) begin
               side_ff[i] <= side_ff[i-1];
            end
         end
      end
   end

   ctl_type       c_end;
   logic [MB-1:0] quo, rem, hi, lo;
   logic          pnz, pneg;
   logic [WORD_BITS-1:0] s_ac, s_mq, s_mbr;
   logic s_acw, s_mqw, s_mbrw, s_ovf, s_dz;

   assign c_end = ctl[MB];
   assign {s_ac, s_acw, s_mq, s_mqw, s_mbr, s_mbrw, s_ovf, s_dz} = side_ff[MB-1];
   assign quo  = av[MB];
   assign rem  = accv[MB][MB-1:0];
   assign lo   = accv[MB][MB-1:0];
   assign hi   = accv[MB][2*MB-1:MB];
   assign pnz  = (accv[MB] != '0);
   assign pneg = (c_end.neg_a != c_end.neg_b) && pnz;

   logic                 v_ff;
   logic [WORD_BITS-1:0] ac_ff, mq_ff, mbr_ff;
   logic                 acw_ff, mqw_ff, mbrw_ff, ovf_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= c_end.valid;
      end
      if (advance) begin
         acw_ff <= s_acw; mqw_ff <= s_mqw; mbrw_ff <= s_mbrw;
         ovf_ff <= s_ovf; dz_ff <= s_dz; mbr_ff <= s_mbr;
         if (c_end.is_mul) begin
            ac_ff <= {pneg, hi}; mq_ff <= {pneg, lo};
            acw_ff <= 1'b1; mqw_ff <= 1'b1;
         end else if (c_end.is_div) begin
            ac_ff  <= (rem == '0) ? '0 : {c_end.neg_a, rem};
            mq_ff  <= (quo == '0) ? '0 : {c_end.neg_a ^ c_end.neg_b, quo};
            acw_ff <= 1'b1; mqw_ff <= 1'b1;
         end else begin
            ac_ff <= s_ac; mq_ff <= s_mq;
         end
      end
   end

   assign rsp_valid          = v_ff;
   assign rsp_ac_out         = ac_ff;
   assign rsp_ac_write       = acw_ff;
   assign rsp_mq_out         = mq_ff;
   assign rsp_mq_write       = mqw_ff;
   assign rsp_mbr_out        = mbr_ff;
   assign rsp_mbr_write      = mbrw_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_divide_by_zero = dz_ff;

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall) else $error("chain moved while full");
   a_dz_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> !(rsp_ac_write || rsp_mq_write))
      else $error("write on divide by zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall) |-> $stable(rsp_ac_out))
      else $error("held beat changed");

endmodule
